[sv/srcc_pkg.sv]
`timescale 1ns / 1ps

package srcc_pkg;

	localparam logic [7:0]  CRC_POLY   = 8'h31;
	localparam logic [7:0]  CRC_INIT   = 8'hFF;
	localparam logic [10:0] READY_MASK = 11'h7FF;
	localparam logic [1:0]  WPF_RESET  = 2'd3;
	localparam int          NUM_WORDS  = 3;

	localparam logic [14:0] TEMP_SCALE  = 15'd17500;
	localparam logic [13:0] HUM_SCALE   = 14'd10000;
	localparam logic [14:0] TEMP_OFFSET = 15'd4500;

	typedef enum logic [1:0] {
		PH_HIGH = 2'd0,
		PH_LOW  = 2'd1,
		PH_CRC  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [15:0] w0;
		logic [15:0] w1;
		logic [15:0] w2;
		logic        crc_ok;
		logic [1:0]  bad;
	} frame_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [7:0] crc8(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

[sv/srcc_front.sv]
`timescale 1ns / 1ps

module srcc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_wpf,
	input  logic                in_take,
	input  logic [7:0]          rx_byte,
	input  logic                frame_start,
	output logic                push,
	output srcc_pkg::frame_rec_t push_rec
);
	import srcc_pkg::*;

	logic [1:0]  wpf_q;
	logic [1:0]  word_q, word_e, word_n, nwords;
	phase_t      phase_q, phase_e, phase_n;
	logic [7:0]  crc_q, crc_n;
	logic [7:0]  hi_q, hi_n;
	logic [15:0] words_q [NUM_WORDS];
	logic [15:0] words_e [NUM_WORDS];
	logic [15:0] words_n [NUM_WORDS];
	logic        good_q, good_e, good_n;
	logic [1:0]  bad_q, bad_e, bad_n;
	logic        active, done;

	always_comb begin
		nwords  = (wpf_q == 2'd0) ? 2'd1 : wpf_q;
		// frame start restarts the frame, then this byte is byte 0
		word_e  = frame_start ? 2'd0 : word_q;
		phase_e = frame_start ? PH_HIGH : phase_q;
		good_e  = frame_start ? 1'b1 : good_q;
		bad_e   = frame_start ? 2'd0 : bad_q;
		for (int i = 0; i < NUM_WORDS; i++) begin
			words_e[i] = frame_start ? 16'd0 : words_q[i];
		end
		active  = word_e < nwords;

		word_n  = word_e;
		phase_n = phase_e;
		good_n  = good_e;
		bad_n   = bad_e;
		crc_n   = frame_start ? CRC_INIT : crc_q;
		hi_n    = frame_start ? 8'd0 : hi_q;
		words_n = words_e;
		done    = 1'b0;

		if (active) begin
			case (phase_e)
				PH_HIGH: begin
					hi_n    = rx_byte;
					crc_n   = crc8(CRC_INIT, rx_byte);
					phase_n = PH_LOW;
				end
				PH_LOW: begin
					crc_n = crc8(crc_q, rx_byte);
					for (int i = 0; i < NUM_WORDS; i++) begin
						if (word_e == 2'(i)) begin
							words_n[i] = {hi_q, rx_byte};
						end
					end
					phase_n = PH_CRC;
				end
				PH_CRC: begin
					if (crc_q != rx_byte && good_e) begin
						good_n = 1'b0;
						bad_n  = word_e;
					end
					crc_n   = CRC_INIT;
					phase_n = PH_HIGH;
					word_n  = word_e + 2'd1;
					done    = (word_e + 2'd1) == nwords;
				end
				default: begin
					phase_n = PH_HIGH;
				end
			endcase
		end
	end

	assign push            = in_take && done;
	assign push_rec.w0     = words_e[0];
	assign push_rec.w1     = words_e[1];
	assign push_rec.w2     = words_e[2];
	assign push_rec.crc_ok = good_n;
	assign push_rec.bad    = bad_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpf_q   <= WPF_RESET;
			word_q  <= 2'd0;
			phase_q <= PH_HIGH;
			crc_q   <= CRC_INIT;
			hi_q    <= 8'd0;
			good_q  <= 1'b1;
			bad_q   <= 2'd0;
			for (int i = 0; i < NUM_WORDS; i++) begin
				words_q[i] <= 16'd0;
			end
		end else begin
			if (cfg_we) begin
				wpf_q <= cfg_wpf;
			end
			if (in_take) begin
				word_q  <= word_n;
				phase_q <= phase_n;
				crc_q   <= crc_n;
				hi_q    <= hi_n;
				good_q  <= good_n;
				bad_q   <= bad_n;
				words_q <= words_n;
			end
		end
	end

endmodule

[sv/srcc_queue.sv]
`timescale 1ns / 1ps

module srcc_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  srcc_pkg::frame_rec_t push_rec,
	input  logic                 pop,
	output srcc_pkg::frame_rec_t pop_rec,
	output srcc_pkg::q_status_t  status
);
	import srcc_pkg::*;

	frame_rec_t mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign pop_rec      = mem_q[rd_ptr_q];
	assign status.full  = count_q == 2'd2;
	assign status.empty = count_q == 2'd0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[sv/srcc_back.sv]
`timescale 1ns / 1ps

module srcc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  srcc_pkg::q_status_t  q_status,
	input  srcc_pkg::frame_rec_t q_rec,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [15:0]          co2_ppm,
	output logic [15:0]          temperature_word,
	output logic [15:0]          humidity_word,
	output logic signed [14:0]   temperature_centi,
	output logic [13:0]          humidity_centi,
	output logic                 data_ready,
	output logic                 crc_ok,
	output logic [1:0]           bad_word
);
	import srcc_pkg::*;

	logic        valid_s1;
	frame_rec_t  rec_s1;
	logic [30:0] tprod_s1;
	logic [29:0] hprod_s1;
	logic        out_valid_q;
	logic        load_out, adv_s1;
	logic [31:0] tsum, hsum;
	logic [14:0] tq;
	logic [13:0] hq;

	assign load_out = !out_valid_q || !out_stall;
	assign adv_s1   = !valid_s1 || load_out;
	assign pop      = adv_s1 && !q_status.empty;

	// divide by 65535: q = (x + (x >> 16) + 1) >> 16, exact for these ranges
	assign tsum = {1'b0, tprod_s1} + 32'(tprod_s1[30:16]) + 32'd1;
	assign hsum = {2'b0, hprod_s1} + 32'(hprod_s1[29:16]) + 32'd1;
	assign tq   = tsum[30:16];
	assign hq   = hsum[29:16];

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_s1   <= q_rec;
			tprod_s1 <= 31'(q_rec.w1) * 31'(TEMP_SCALE);
			hprod_s1 <= 30'(q_rec.w2) * 30'(HUM_SCALE);
		end
		if (load_out && valid_s1) begin
			co2_ppm           <= rec_s1.w0;
			temperature_word  <= rec_s1.w1;
			humidity_word     <= rec_s1.w2;
			temperature_centi <= signed'(tq - TEMP_OFFSET);
			humidity_centi    <= hq;
			data_ready        <= (rec_s1.w0[10:0] & READY_MASK) != 11'd0;
			crc_ok            <= rec_s1.crc_ok;
			bad_word          <= rec_s1.bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= pop;
			end
			if (load_out) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[sv/sensor_response_crc_checker_core.sv]
`timescale 1ns / 1ps
// Channel  | Handshake                  | Payload
// input    | in_valid / in_stall        | rx_byte, frame_start
// result   | out_valid / out_stall      | co2_ppm ... bad_word (8 fields)
// config   | cfg_valid / cfg_ready      | words_per_frame
//
// One byte per cycle while in_stall is low. A result leaves the front with the last
// byte of a frame and reaches out_valid via queue, product stage, output register.
// The two-entry frame queue sets when in_stall rises: only with both entries held.
// Reset (arst_n low) gives three words per frame and an empty pipeline.
// cfg_ready is always high.

module sensor_response_crc_checker_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           rx_byte,
	input  logic                 frame_start,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           words_per_frame,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [15:0]          co2_ppm,
	output logic [15:0]          temperature_word,
	output logic [15:0]          humidity_word,
	output logic signed [14:0]   temperature_centi,
	output logic [13:0]          humidity_centi,
	output logic                 data_ready,
	output logic                 crc_ok,
	output logic [1:0]           bad_word
);
	import srcc_pkg::*;

	logic       in_take, push, pop;
	frame_rec_t push_rec, pop_rec;
	q_status_t  q_status;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_status.full;
	assign in_take   = in_valid && !in_stall;

	srcc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_wpf     (words_per_frame),
		.in_take     (in_take),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.push        (push),
		.push_rec    (push_rec)
	);

	srcc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.pop_rec  (pop_rec),
		.status   (q_status)
	);

	srcc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_status          (q_status),
		.q_rec             (pop_rec),
		.pop               (pop),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.co2_ppm           (co2_ppm),
		.temperature_word  (temperature_word),
		.humidity_word     (humidity_word),
		.temperature_centi (temperature_centi),
		.humidity_centi    (humidity_centi),
		.data_ready        (data_ready),
		.crc_ok            (crc_ok),
		.bad_word          (bad_word)
	);

endmodule

[sv/srcc_checker.sv]
`timescale 1ns / 1ps

module srcc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [15:0]        co2_ppm,
	input logic signed [14:0] temperature_centi,
	input logic [13:0]        humidity_centi,
	input logic               data_ready,
	input logic               crc_ok,
	input logic [1:0]         bad_word
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(co2_ppm))
		else $error("result beat dropped or changed under stall");

	a_ready_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> data_ready == (co2_ppm[10:0] != 11'd0))
		else $error("data_ready disagrees with word 0");

	a_crc_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && crc_ok |-> bad_word == 2'd0)
		else $error("bad_word set on a passing frame");

	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> humidity_centi <= 14'd10000 && temperature_centi >= -15'sd4500
			&& temperature_centi <= 15'sd13000)
		else $error("converted value out of range");

endmodule

bind sensor_response_crc_checker_core srcc_checker u_srcc_checker (.*);

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import srcc_pkg::*;

	typedef struct {
		logic [15:0]        co2;
		logic [15:0]        t_word;
		logic [15:0]        h_word;
		logic signed [14:0] t_centi;
		logic [13:0]        h_centi;
		logic               ready;
		logic               ok;
		logic [1:0]         bad;
	} reading_t;

	// Tracks the reply framing and CRC verdict, and holds the readings still owed.
	class reply_scoreboard;
		logic [1:0]  wpf;
		logic [3:0]  pos;
		logic [7:0]  crc_acc;
		logic [7:0]  msb;
		logic [15:0] word_buf [3];
		bit          crc_good;
		logic [1:0]  first_bad;
		reading_t    owed_readings [$];
		int          errors;

		function new();
			wpf = WPF_RESET;
			errors = 0;
			restart();
		endfunction

		// MSB-first bitwise form of the 0x31 CRC
		static function logic [7:0] crc_update(logic [7:0] crc, logic [7:0] b);
			logic fb;
			for (int i = 7; i >= 0; i--) begin
				fb = crc[7] ^ b[i];
				crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
			end
			return crc;
		endfunction

		function void restart();
			pos = 4'd0;
			crc_acc = CRC_INIT;
			msb = 8'h00;
			foreach (word_buf[i]) word_buf[i] = 16'h0000;
			crc_good = 1'b1;
			first_bad = 2'd0;
		endfunction

		function int pending();
			return owed_readings.size();
		endfunction

		// Returns 1 when the byte was used, 0 when the block drops it.
		function bit take_byte(logic [7:0] b, logic fs);
			int       n;
			int       lim;
			int       w;
			int       tc;
			int       hc;
			phase_t   ph;
			reading_t r;
			n = (wpf == 2'd0) ? 1 : int'(wpf);
			lim = 3 * n;
			if (fs) restart();
			if (int'(pos) >= lim) return 1'b0;
			w = int'(pos) / 3;
			ph = phase_t'(2'(int'(pos) % 3));
			case (ph)
				PH_HIGH: begin
					msb = b;
					crc_acc = crc_update(CRC_INIT, b);
				end
				PH_LOW: begin
					crc_acc = crc_update(crc_acc, b);
					word_buf[w] = {msb, b};
				end
				default: begin
					if (crc_acc != b && crc_good) begin
						crc_good = 1'b0;
						first_bad = 2'(w);
					end
					crc_acc = CRC_INIT;
				end
			endcase
			pos = pos + 4'd1;
			if (int'(pos) == lim) begin
				tc = int'(TEMP_SCALE) * int'(word_buf[1]) / 65535;
				hc = int'(HUM_SCALE) * int'(word_buf[2]) / 65535;
				r.co2 = word_buf[0];
				r.t_word = word_buf[1];
				r.h_word = word_buf[2];
				r.t_centi = 15'(tc - int'(TEMP_OFFSET));
				r.h_centi = 14'(hc);
				r.ready = |(word_buf[0][10:0] & READY_MASK);
				r.ok = crc_good;
				r.bad = first_bad;
				owed_readings.push_back(r);
			end
			return 1'b1;
		endfunction

		task report(string field, int got_v, int want_v);
			$display("mismatch at %0t: %s got %0d expected %0d", $time, field, got_v, want_v);
			errors++;
		endtask

		task check_reading(reading_t got);
			reading_t want;
			if (owed_readings.size() == 0) begin
				report("unexpected reading, co2_ppm", int'(got.co2), -1);
				return;
			end
			want = owed_readings.pop_front();
			if (got.co2 !== want.co2) report("co2_ppm", int'(got.co2), int'(want.co2));
			if (got.t_word !== want.t_word)
				report("temperature_word", int'(got.t_word), int'(want.t_word));
			if (got.h_word !== want.h_word)
				report("humidity_word", int'(got.h_word), int'(want.h_word));
			if (got.t_centi !== want.t_centi)
				report("temperature_centi", int'(got.t_centi), int'(want.t_centi));
			if (got.h_centi !== want.h_centi)
				report("humidity_centi", int'(got.h_centi), int'(want.h_centi));
			if (got.ready !== want.ready) report("data_ready", int'(got.ready), int'(want.ready));
			if (got.ok !== want.ok) report("crc_ok", int'(got.ok), int'(want.ok));
			if (got.bad !== want.bad) report("bad_word", int'(got.bad), int'(want.bad));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [7:0]           rx_byte = 8'h00;
	logic                 frame_start = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [1:0]           words_per_frame = 2'd0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [15:0]          co2_ppm;
	logic [15:0]          temperature_word;
	logic [15:0]          humidity_word;
	logic signed [14:0]   temperature_centi;
	logic [13:0]          humidity_centi;
	logic                 data_ready;
	logic                 crc_ok;
	logic [1:0]           bad_word;

	reply_scoreboard sb;
	int  bytes_taken = 0;
	bit  jitter = 1'b1;
	bit  hold_req = 1'b0;

	sensor_response_crc_checker_core u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.rx_byte           (rx_byte),
		.frame_start       (frame_start),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.words_per_frame   (words_per_frame),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.co2_ppm           (co2_ppm),
		.temperature_word  (temperature_word),
		.humidity_word     (humidity_word),
		.temperature_centi (temperature_centi),
		.humidity_centi    (humidity_centi),
		.data_ready        (data_ready),
		.crc_ok            (crc_ok),
		.bad_word          (bad_word)
	);

	always #10 clk = ~clk;

	initial begin
		#5ms;
		$display("testbench failed");
		$finish;
	end

	// Handshakes are sampled mid-cycle, where inputs and outputs have settled.
	always @(negedge clk) begin
		if (arst_n && in_valid && !in_stall)
			bytes_taken += int'(sb.take_byte(rx_byte, frame_start));
	end

	always @(negedge clk) begin
		reading_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.co2 = co2_ppm;
			got.t_word = temperature_word;
			got.h_word = humidity_word;
			got.t_centi = temperature_centi;
			got.h_centi = humidity_centi;
			got.ready = data_ready;
			got.ok = crc_ok;
			got.bad = bad_word;
			sb.check_reading(got);
		end
	end

	// Result side: random stall bursts, plus one long hold-off on request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (80) @(posedge clk);
				out_stall <= 1'b0;
			end else if (jitter && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic fs);
		bit acc;
		in_valid <= 1'b1;
		rx_byte <= b;
		frame_start <= fs;
		do begin
			@(negedge clk);
			acc = !in_stall;
			@(posedge clk);
		end while (!acc);
		if (jitter && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic send_word(input logic [15:0] w, input logic fs, input bit corrupt);
		logic [7:0] c;
		c = reply_scoreboard::crc_update(reply_scoreboard::crc_update(CRC_INIT, w[15:8]), w[7:0]);
		if (corrupt) c ^= 8'($urandom_range(1, 255));
		send_byte(w[15:8], fs);
		send_byte(w[7:0], 1'b0);
		send_byte(c, 1'b0);
	endtask

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return {5'($urandom), 11'h000};
			3: return 16'($urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_frame(input int n, input bit allow_bad);
		int bad;
		bit corrupt;
		bad = -1;
		if (allow_bad && $urandom_range(0, 3) == 0) bad = $urandom_range(0, n - 1);
		for (int i = 0; i < n; i++) begin
			corrupt = (i == bad) || (bad >= 0 && i > bad && $urandom_range(0, 1) == 1);
			send_word(pick_word(), i == 0, corrupt);
		end
	endtask

	// Stop offering bytes, wait for every owed reading, then let the pipeline settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [1:0] v);
		bit acc;
		cfg_valid <= 1'b1;
		words_per_frame <= v;
		do begin
			@(negedge clk);
			acc = cfg_ready;
			@(posedge clk);
		end while (!acc);
		cfg_valid <= 1'b0;
		sb.wpf = v;
	endtask

	task automatic run_phase(input int target);
		int start;
		int n;
		start = bytes_taken;
		n = (sb.wpf == 2'd0) ? 1 : int'(sb.wpf);
		while (bytes_taken - start < target) begin
			case ($urandom_range(0, 9))
				7: begin
					// cut short by the next frame start
					send_byte(8'($urandom), 1'b1);
					repeat ($urandom_range(0, 3 * n - 2)) send_byte(8'($urandom), 1'b0);
				end
				8: begin
					repeat ($urandom_range(1, 6))
						send_byte(8'($urandom), $urandom_range(0, 3) == 0);
				end
				9: begin
					send_frame(n, 1'b1);
					repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
				end
				default: send_frame(n, 1'b1);
			endcase
		end
		drain();
	endtask

	initial begin
		logic [1:0] settings [8];
		logic [7:0] c;
		settings = '{2'd1, 2'd3, 2'd2, 2'd0, 2'd1, 2'd2, 2'd3, 2'd3};
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first reply arrives without a frame start; extremes of the conversions
		send_word(16'h0801, 1'b0, 1'b0);
		send_word(16'hFFFF, 1'b0, 1'b0);
		send_word(16'hFFFF, 1'b0, 1'b0);
		send_byte(8'hA5, 1'b0);
		send_word(16'h0800, 1'b1, 1'b0);
		send_word(16'h0000, 1'b0, 1'b1);
		send_word(16'h0000, 1'b0, 1'b1);
		drain();
		write_cfg(2'd1);
		send_word(16'hFFFF, 1'b1, 1'b1);
		drain();
		write_cfg(2'd0);
		send_word(16'h07FF, 1'b1, 1'b0);
		drain();

		// shorten the frame once the position has already passed the new length
		write_cfg(2'd3);
		send_byte(8'h12, 1'b1);
		send_byte(8'h34, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h56, 1'b0);
		drain();
		write_cfg(2'd1);
		send_byte(8'h78, 1'b0);
		send_byte(8'h9A, 1'b0);
		drain();

		// lengthen the frame part-way through its first word
		send_byte(8'hBE, 1'b1);
		drain();
		write_cfg(2'd3);
		c = reply_scoreboard::crc_update(reply_scoreboard::crc_update(CRC_INIT, 8'hBE), 8'hEF);
		send_byte(8'hEF, 1'b0);
		send_byte(c, 1'b0);
		send_word(16'h8000, 1'b0, 1'b0);
		send_word(16'h7FFF, 1'b0, 1'b0);
		drain();

		for (int p = 0; p < 8; p++) begin
			write_cfg(settings[p]);
			if (p == 7) jitter = 1'b0;
			if (p == 0) begin
				// fill the block while the result side holds off
				@(negedge clk) hold_req = 1'b1;
				@(posedge clk);
				jitter = 1'b0;
				repeat (12) send_frame(1, 1'b0);
				jitter = 1'b1;
				drain();
			end
			run_phase(150);
		end

		drain();
		if (sb.errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
